[design/emsa_pkg.sv]
// ----------------------------------------------------------------------------
// emsa_pkg
// Shared constants and handshake structs for the energy meter accumulator.
// ----------------------------------------------------------------------------
package emsa_pkg;

    localparam int TAPS       = 4;
    localparam int TAP_W      = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int NUM_COEFF  = 4;
    localparam int Q15_SHIFT  = 15;
    localparam int MUL_A_W    = 16;
    localparam int MUL_B_W    = 32;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int RAW_W      = 34;
    localparam int CNT_W      = 24;
    localparam int SMP_W      = 10;
    localparam int ACC_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_COEFF_3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_A      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_B      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_SHIFT = 3'd6;

    localparam logic [15:0] COEFF_RESET       = 16'd8192;
    localparam logic [15:0] GAIN_RESET        = 16'd16384;
    localparam logic [15:0] BETA_RESET        = 16'd0;
    localparam logic [5:0]  POWER_SHIFT_RESET = 6'd32;

    localparam logic [0:0] REQ_SAMPLE = 1'b0;

    typedef struct packed {
        logic                      start;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                      done;
        logic signed [MUL_P_W-1:0] p;
    } t_mul_rsp;

    typedef struct packed {
        logic             start;
        logic [RAW_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SMP_W-1:0] q;
    } t_div_rsp;

endpackage

[design/emsa_mul.sv]
// ----------------------------------------------------------------------------
// emsa_mul
// Bit-serial signed multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module emsa_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  emsa_pkg::t_mul_req i_req,
    output emsa_pkg::t_mul_rsp o_rsp
);
    import emsa_pkg::*;

    localparam int HI_W  = MUL_B_W + 2;
    localparam int CNT_W_M = $clog2(MUL_A_W);

    logic signed [HI_W-1:0]  r_hi;
    logic [MUL_A_W-1:0]      r_lo;
    logic signed [HI_W-1:0]  r_b;
    logic [CNT_W_M-1:0]      r_cnt;
    logic                    r_run;
    logic                    r_done;
    logic signed [HI_W-1:0]  addend;
    logic signed [HI_W-1:0]  sum;
    logic                    last;

    always_comb begin
        last   = (r_cnt == CNT_W_M'(MUL_A_W - 1));
        addend = r_lo[0] ? (last ? -r_b : r_b) : '0;
        sum    = r_hi + addend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_hi  <= '0;
                r_lo  <= i_req.a;
                r_b   <= HI_W'(i_req.b);
                r_cnt <= '0;
                r_run <= 1'b1;
            end else if (r_run) begin
                r_hi  <= {sum[HI_W-1], sum[HI_W-1:1]};
                r_lo  <= {sum[0], r_lo[MUL_A_W-1:1]};
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = {r_hi[MUL_B_W-1:0], r_lo};

endmodule

[design/emsa_div.sv]
// ----------------------------------------------------------------------------
// emsa_div
// Restoring divider for the interval means, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module emsa_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  emsa_pkg::t_div_req i_req,
    output emsa_pkg::t_div_rsp o_rsp
);
    import emsa_pkg::*;

    localparam int STEP_W = $clog2(RAW_W);

    logic [CNT_W-1:0]  r_rem;
    logic [RAW_W-1:0]  r_q;
    logic [CNT_W-1:0]  r_d;
    logic [STEP_W-1:0] r_cnt;
    logic              r_run;
    logic              r_done;
    logic [CNT_W:0]    trial;
    logic              ge;
    logic [CNT_W:0]    diff;

    always_comb begin
        trial = {r_rem, r_q[RAW_W-1]};
        ge    = (trial >= {1'b0, r_d});
        diff  = trial - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem <= '0;
                r_q   <= i_req.dividend;
                r_d   <= i_req.divisor;
                r_cnt <= '0;
                r_run <= 1'b1;
            end else if (r_run) begin
                r_rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
                r_q   <= {r_q[RAW_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(RAW_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q[SMP_W-1:0];

endmodule

[design/energy_meter_sample_accumulator.sv]
// ----------------------------------------------------------------------------
// energy_meter_sample_accumulator
// Single-phase energy meter front end: offset removal, FIR, phase correction,
// square and power accumulation, interval close with new DC offsets.
//
// Input channel (i_in_valid / o_in_ready): a sample transaction or a close
// transaction. A sample runs 17 products through one bit-serial multiplier,
// one after another, and the input is not ready again until it is done. A
// close runs two serial divisions by the count (skipped for a zero count),
// then loads the output register.
// Output channel (o_out_valid / i_out_ready): one transaction per close,
// held in an output register; samples are still taken while it waits. A
// close stays in its last step until the output register is free.
// Configuration channel (i_cfg_valid / o_cfg_ready): always ready, write
// only while idle. Index 7 is ignored.
// Reset clears all delay lines, totals, offsets and restores register
// defaults; the first transaction is taken the cycle after reset releases.
// ----------------------------------------------------------------------------
module energy_meter_sample_accumulator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [0:0]                       i_req_type,
    input  logic [emsa_pkg::SMP_W-1:0]       i_current_sample,
    input  logic [emsa_pkg::SMP_W-1:0]       i_voltage_sample,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [emsa_pkg::ACC_W-1:0]       o_current_square_sum,
    output logic [emsa_pkg::ACC_W-1:0]       o_voltage_square_sum,
    output logic signed [emsa_pkg::ACC_W-1:0] o_power_sum,
    output logic [emsa_pkg::CNT_W-1:0]       o_sample_count,
    output logic [emsa_pkg::SMP_W-1:0]       o_current_offset,
    output logic [emsa_pkg::SMP_W-1:0]       o_voltage_offset,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [emsa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [emsa_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import emsa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_FIRC, S_FIRV, S_BETA, S_GAIN, S_SQC, S_SQV,
        S_PWR, S_FIRP, S_DIVC, S_DIVV, S_EMIT
    } t_state;

    t_state r_state;
    logic   r_wait;
    logic [TAP_W-1:0] r_tap;

    logic signed [15:0] r_coeff [NUM_COEFF];
    logic signed [15:0] r_gain;
    logic signed [15:0] r_beta;
    logic [5:0]         r_pshift;

    logic signed [15:0] r_cline [TAPS];
    logic signed [15:0] r_vline [TAPS];
    logic signed [15:0] r_pline [TAPS];
    logic signed [15:0] r_prev;
    logic [RAW_W-1:0]   r_craw;
    logic [RAW_W-1:0]   r_vraw;
    logic [ACC_W-1:0]   r_csq;
    logic [ACC_W-1:0]   r_vsq;
    logic [ACC_W-1:0]   r_ptot;
    logic [CNT_W-1:0]   r_count;
    logic [SMP_W-1:0]   r_coff;
    logic [SMP_W-1:0]   r_voff;

    logic [15:0]        r_acc;
    logic signed [15:0] r_fc;
    logic signed [15:0] r_fv;
    logic signed [15:0] r_vr;
    logic signed [31:0] r_inner;

    logic               r_out_valid;
    logic [ACC_W-1:0]   r_o_csq;
    logic [ACC_W-1:0]   r_o_vsq;
    logic [ACC_W-1:0]   r_o_ptot;
    logic [CNT_W-1:0]   r_o_count;
    logic [SMP_W-1:0]   r_o_coff;
    logic [SMP_W-1:0]   r_o_voff;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic               last_tap;
    logic [15:0]        term;
    logic [15:0]        fir_sum;
    logic [15:0]        vr_val;
    logic signed [ACC_W-1:0] pw_shifted;
    logic               out_free;

    emsa_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    emsa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        mul_req.a = r_coeff[2'(r_tap)];
        mul_req.b = 32'(r_cline[r_tap]);
        case (r_state)
            S_FIRC: begin
                mul_req.a = r_coeff[2'(r_tap)];
                mul_req.b = 32'(r_cline[r_tap]);
            end
            S_FIRV: begin
                mul_req.a = r_coeff[2'(r_tap)];
                mul_req.b = 32'(r_vline[r_tap]);
            end
            S_FIRP: begin
                mul_req.a = r_coeff[2'(r_tap)];
                mul_req.b = 32'(r_pline[r_tap]);
            end
            S_BETA: begin
                mul_req.a = r_beta;
                mul_req.b = 32'(r_prev);
            end
            S_GAIN: begin
                mul_req.a = r_gain;
                mul_req.b = r_inner;
            end
            S_SQC: begin
                mul_req.a = r_fc;
                mul_req.b = 32'(r_fc);
            end
            S_SQV: begin
                mul_req.a = r_vr;
                mul_req.b = 32'(r_vr);
            end
            S_PWR: begin
                mul_req.a = r_vr;
                mul_req.b = 32'(r_fc);
            end
            default: begin
            end
        endcase
        mul_req.start = !r_wait && (r_state inside {S_FIRC, S_FIRV, S_FIRP, S_BETA,
                                                     S_GAIN, S_SQC, S_SQV, S_PWR});

        div_req.start    = !r_wait && (r_state inside {S_DIVC, S_DIVV});
        div_req.dividend = (r_state == S_DIVV) ? r_vraw : r_craw;
        div_req.divisor  = r_count;

        last_tap   = (r_tap == TAP_W'(TAPS - 1));
        term       = mul_rsp.p[Q15_SHIFT+15:Q15_SHIFT];
        fir_sum    = r_acc + term;
        vr_val     = mul_rsp.p[43:28] +
                     {15'd0, mul_rsp.p[MUL_P_W-1] && (|mul_rsp.p[27:0])};
        pw_shifted = ACC_W'($signed(mul_rsp.p[31:0])) >>> r_pshift;
        out_free   = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_tap       <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_COEFF; i++) r_coeff[i] <= COEFF_RESET;
            r_gain   <= GAIN_RESET;
            r_beta   <= BETA_RESET;
            r_pshift <= POWER_SHIFT_RESET;
            for (int i = 0; i < TAPS; i++) begin
                r_cline[i] <= '0;
                r_vline[i] <= '0;
                r_pline[i] <= '0;
            end
            r_prev  <= '0;
            r_craw  <= '0;
            r_vraw  <= '0;
            r_csq   <= '0;
            r_vsq   <= '0;
            r_ptot  <= '0;
            r_count <= '0;
            r_coff  <= '0;
            r_voff  <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index <= REG_COEFF_3) begin
                    r_coeff[2'(i_cfg_index)] <= i_cfg_data;
                end else if (i_cfg_index == REG_GAIN_A) begin
                    r_gain <= i_cfg_data;
                end else if (i_cfg_index == REG_BETA_B) begin
                    r_beta <= i_cfg_data;
                end else if (i_cfg_index == REG_POWER_SHIFT) begin
                    r_pshift <= i_cfg_data[5:0];
                end
            end

            if (r_out_valid && i_out_ready && r_state != S_EMIT) r_out_valid <= 1'b0;

            if (mul_req.start || div_req.start) r_wait <= 1'b1;

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_req_type == REQ_SAMPLE) begin
                            if (r_count != COUNT_MAX) begin
                                r_count <= r_count + 1'b1;
                                r_craw  <= r_craw + RAW_W'(i_current_sample);
                                r_vraw  <= r_vraw + RAW_W'(i_voltage_sample);
                            end
                            r_cline[0] <= 16'(i_current_sample) - 16'(r_coff);
                            r_vline[0] <= 16'(i_voltage_sample) - 16'(r_voff);
                            r_tap      <= '0;
                            r_acc      <= '0;
                            r_state    <= S_FIRC;
                        end else begin
                            r_state <= (r_count != '0) ? S_DIVC : S_EMIT;
                        end
                    end
                end
                S_FIRC, S_FIRV, S_FIRP: begin
                    if (r_wait && mul_rsp.done) begin
                        r_wait <= 1'b0;
                        if (last_tap) begin
                            r_acc <= '0;
                            r_tap <= '0;
                            if (r_state == S_FIRC) begin
                                r_fc <= fir_sum;
                                for (int i = 1; i < TAPS; i++) r_cline[i] <= r_cline[i-1];
                                r_state <= S_FIRV;
                            end else if (r_state == S_FIRV) begin
                                r_fv <= fir_sum;
                                for (int i = 1; i < TAPS; i++) r_vline[i] <= r_vline[i-1];
                                r_state <= S_BETA;
                            end else begin
                                r_ptot <= r_ptot + ACC_W'($signed(fir_sum));
                                for (int i = 1; i < TAPS; i++) r_pline[i] <= r_pline[i-1];
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_acc <= fir_sum;
                            r_tap <= r_tap + 1'b1;
                        end
                    end
                end
                S_BETA: begin
                    if (r_wait && mul_rsp.done) begin
                        r_wait  <= 1'b0;
                        r_inner <= (32'(r_fv) <<< 14) + mul_rsp.p[31:0];
                        r_prev  <= r_fv;
                        r_state <= S_GAIN;
                    end
                end
                S_GAIN: begin
                    if (r_wait && mul_rsp.done) begin
                        r_wait  <= 1'b0;
                        r_vr    <= vr_val;
                        r_state <= S_SQC;
                    end
                end
                S_SQC: begin
                    if (r_wait && mul_rsp.done) begin
                        r_wait  <= 1'b0;
                        r_csq   <= r_csq + ACC_W'(mul_rsp.p[31:0]);
                        r_state <= S_SQV;
                    end
                end
                S_SQV: begin
                    if (r_wait && mul_rsp.done) begin
                        r_wait  <= 1'b0;
                        r_vsq   <= r_vsq + ACC_W'(mul_rsp.p[31:0]);
                        r_state <= S_PWR;
                    end
                end
                S_PWR: begin
                    if (r_wait && mul_rsp.done) begin
                        r_wait     <= 1'b0;
                        r_pline[0] <= pw_shifted[15:0];
                        r_state    <= S_FIRP;
                    end
                end
                S_DIVC: begin
                    if (r_wait && div_rsp.done) begin
                        r_wait  <= 1'b0;
                        r_coff  <= div_rsp.q;
                        r_state <= S_DIVV;
                    end
                end
                S_DIVV: begin
                    if (r_wait && div_rsp.done) begin
                        r_wait  <= 1'b0;
                        r_voff  <= div_rsp.q;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_csq     <= r_csq;
                        r_o_vsq     <= r_vsq;
                        r_o_ptot    <= r_ptot;
                        r_o_count   <= r_count;
                        r_o_coff    <= r_coff;
                        r_o_voff    <= r_voff;
                        r_craw      <= '0;
                        r_vraw      <= '0;
                        r_csq       <= '0;
                        r_vsq       <= '0;
                        r_ptot      <= '0;
                        r_count     <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready           = (r_state == S_IDLE);
    assign o_cfg_ready          = 1'b1;
    assign o_out_valid          = r_out_valid;
    assign o_current_square_sum = r_o_csq;
    assign o_voltage_square_sum = r_o_vsq;
    assign o_power_sum          = r_o_ptot;
    assign o_sample_count       = r_o_count;
    assign o_current_offset     = r_o_coff;
    assign o_voltage_offset     = r_o_voff;

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Runs the energy meter accumulator through directed and random sample and
// close transactions under several register settings. A transaction-level model
// predicts each interval result, and a monitor compares every output
// transaction field by field.
// ----------------------------------------------------------------------------
module testbench;
    import emsa_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_COEFF_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;
    localparam logic [0:0]           REQ_CLOSE   = 1'b1;
    localparam int SETTLE_CYCLES = 400;
    localparam int CYCLE_LIMIT   = 3000000;

    typedef struct packed {
        logic [ACC_W-1:0]        cur_sq;
        logic [ACC_W-1:0]        vol_sq;
        logic signed [ACC_W-1:0] power;
        logic [CNT_W-1:0]        count;
        logic [SMP_W-1:0]        cur_off;
        logic [SMP_W-1:0]        vol_off;
    } t_interval_totals;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    logic [0:0] i_req_type;
    logic [SMP_W-1:0] i_current_sample;
    logic [SMP_W-1:0] i_voltage_sample;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [ACC_W-1:0] o_current_square_sum;
    logic [ACC_W-1:0] o_voltage_square_sum;
    logic signed [ACC_W-1:0] o_power_sum;
    logic [CNT_W-1:0] o_sample_count;
    logic [SMP_W-1:0] o_current_offset;
    logic [SMP_W-1:0] o_voltage_offset;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    energy_meter_sample_accumulator u_dut (.*);

    always #2 i_clk = ~i_clk;

    // model state
    logic signed [15:0] m_coeff [4];
    logic signed [15:0] m_gain;
    logic signed [15:0] m_beta;
    logic [5:0]         m_shift;
    logic [3:0][15:0]   m_cur_line, m_vol_line, m_pow_line;
    logic signed [15:0] m_prev_fv;
    logic [RAW_W-1:0]   m_cur_raw, m_vol_raw;
    logic [ACC_W-1:0]   m_cur_sq, m_vol_sq, m_power;
    logic [CNT_W-1:0]   m_count;
    logic [SMP_W-1:0]   m_cur_off, m_vol_off;

    t_interval_totals expected_totals [$];
    int errors = 0;
    int cycles = 0;
    int burst_left = 0;
    int max_gap = 8;
    int rx_hold = 0;
    bit rx_stall = 1'b1;

    function automatic logic signed [15:0] fir_sum(input logic [3:0][15:0] line);
        logic [15:0] acc;
        longint p;
        acc = '0;
        for (int i = 0; i < TAPS; i++) begin
            p = longint'(m_coeff[i]) * longint'($signed(line[i]));
            acc = acc + 16'(p >>> Q15_SHIFT);
        end
        return $signed(acc);
    endfunction

    function automatic logic [3:0][15:0] shift_line(input logic [3:0][15:0] line);
        return {line[2], line[1], line[0], line[0]};
    endfunction

    task automatic predict_sample(input logic [SMP_W-1:0] cur, input logic [SMP_W-1:0] vol);
        logic signed [15:0] fc, fv, vr, po;
        longint inner, corr, pw;
        if (m_count != COUNT_MAX) begin
            m_count++;
            m_cur_raw += RAW_W'(cur);
            m_vol_raw += RAW_W'(vol);
        end
        m_cur_line[0] = 16'({6'b0, cur} - {6'b0, m_cur_off});
        fc = fir_sum(m_cur_line);
        m_cur_line = shift_line(m_cur_line);
        m_vol_line[0] = 16'({6'b0, vol} - {6'b0, m_vol_off});
        fv = fir_sum(m_vol_line);
        m_vol_line = shift_line(m_vol_line);
        inner = longint'(fv) * 16384 + longint'(m_beta) * longint'(m_prev_fv);
        corr = (longint'(m_gain) * inner) / 268435456;
        vr = corr[15:0];
        m_prev_fv = fv;
        m_cur_sq += 64'(longint'(fc) * longint'(fc));
        m_vol_sq += 64'(longint'(vr) * longint'(vr));
        pw = (longint'(fc) * longint'(vr)) >>> m_shift;
        m_pow_line[0] = pw[15:0];
        po = fir_sum(m_pow_line);
        m_pow_line = shift_line(m_pow_line);
        m_power += 64'(longint'(po));
    endtask

    task automatic predict_close();
        t_interval_totals t;
        if (m_count != 0) begin
            m_cur_off = SMP_W'(m_cur_raw / m_count);
            m_vol_off = SMP_W'(m_vol_raw / m_count);
        end
        t = '{m_cur_sq, m_vol_sq, m_power, m_count, m_cur_off, m_vol_off};
        expected_totals.push_back(t);
        m_cur_raw = '0; m_vol_raw = '0; m_cur_sq = '0; m_vol_sq = '0;
        m_power = '0; m_count = '0;
    endtask

    task automatic send_item(input logic [0:0] req, input logic [SMP_W-1:0] cur,
                             input logic [SMP_W-1:0] vol);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_current_sample <= cur;
        i_voltage_sample <= vol;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        if (req == REQ_SAMPLE)
            predict_sample(cur, vol);
        else
            predict_close();
    endtask

    task automatic send_sample_random();
        send_item(REQ_SAMPLE, SMP_W'($urandom), SMP_W'($urandom));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_totals.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_COEFF_0, REG_COEFF_1, REG_COEFF_2, REG_COEFF_3: m_coeff[idx[1:0]] = data;
            REG_GAIN_A: m_gain = data;
            REG_BETA_B: m_beta = data;
            REG_POWER_SHIFT: m_shift = data[5:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_all(input logic [15:0] c0, input logic [15:0] c1,
                             input logic [15:0] c2, input logic [15:0] c3,
                             input logic [15:0] g, input logic [15:0] b,
                             input logic [15:0] s);
        drain();
        write_reg(REG_COEFF_0, c0);
        write_reg(REG_COEFF_1, c1);
        write_reg(REG_COEFF_2, c2);
        write_reg(REG_COEFF_3, c3);
        write_reg(REG_GAIN_A, g);
        write_reg(REG_BETA_B, b);
        write_reg(REG_POWER_SHIFT, s);
    endtask

    task automatic test_default_extremes();
        send_item(REQ_CLOSE, '0, '0);
        send_item(REQ_SAMPLE, '0, '0);
        send_item(REQ_SAMPLE, 10'h3FF, 10'h3FF);
        send_item(REQ_SAMPLE, 10'h3FF, '0);
        send_item(REQ_SAMPLE, '0, 10'h3FF);
        send_item(REQ_SAMPLE, 10'h2AA, 10'h155);
        send_item(REQ_CLOSE, 10'h3FF, 10'h3FF);
        send_item(REQ_CLOSE, 10'h155, 10'h2AA);
        send_item(REQ_SAMPLE, '0, '0);
        send_item(REQ_SAMPLE, 10'h3FF, 10'h3FF);
        send_item(REQ_CLOSE, '0, '0);
    endtask

    task automatic test_config_extremes();
        write_all(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'd0);
        write_reg(REG_UNUSED, 16'hFFFF);
        for (int i = 0; i < 4; i++) send_item(REQ_SAMPLE, i[0] ? 10'h3FF : 10'h0, 10'h3FF);
        send_item(REQ_CLOSE, '0, '0);
        write_all(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'd63);
        for (int i = 0; i < 4; i++) send_item(REQ_SAMPLE, 10'h3FF, i[0] ? 10'h3FF : 10'h0);
        send_item(REQ_CLOSE, '0, '0);
    endtask

    task automatic test_backpressure();
        drain();
        rx_hold = 4000;
        max_gap = 0;
        send_item(REQ_SAMPLE, 10'h123, 10'h321);
        send_item(REQ_CLOSE, '0, '0);
        send_item(REQ_CLOSE, '0, '0);
        send_item(REQ_SAMPLE, 10'h200, 10'h1FF);
        send_item(REQ_CLOSE, '0, '0);
        send_item(REQ_SAMPLE, 10'h050, 10'h3A0);
        max_gap = 8;
        drain();
    endtask

    task automatic test_random_intervals();
        int left;
        int phase_items;
        left = 880;
        while (left > 0) begin
            if ($urandom_range(0, 2) == 0)
                write_all(COEFF_RESET, COEFF_RESET, COEFF_RESET, COEFF_RESET,
                          GAIN_RESET, BETA_RESET, 16'(POWER_SHIFT_RESET));
            else
                write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom_range(0, 63)));
            max_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            rx_stall = $urandom_range(0, 3) != 0;
            phase_items = $urandom_range(60, 140);
            for (int i = 0; i < phase_items && left > 0; i++) begin
                if ($urandom_range(0, 11) == 0)
                    send_item(REQ_CLOSE, SMP_W'($urandom), SMP_W'($urandom));
                else
                    send_sample_random();
                left--;
            end
            send_item(REQ_CLOSE, '0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= rx_stall ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_interval_totals t;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_totals.size() == 0) begin
                $error("unexpected output transaction");
                errors++;
            end else begin
                t = expected_totals.pop_front();
                if (o_current_square_sum !== t.cur_sq) begin
                    $error("current_square_sum exp %h got %h", t.cur_sq, o_current_square_sum);
                    errors++;
                end
                if (o_voltage_square_sum !== t.vol_sq) begin
                    $error("voltage_square_sum exp %h got %h", t.vol_sq, o_voltage_square_sum);
                    errors++;
                end
                if (o_power_sum !== t.power) begin
                    $error("power_sum exp %h got %h", t.power, o_power_sum);
                    errors++;
                end
                if (o_sample_count !== t.count) begin
                    $error("sample_count exp %h got %h", t.count, o_sample_count);
                    errors++;
                end
                if (o_current_offset !== t.cur_off) begin
                    $error("current_offset exp %h got %h", t.cur_off, o_current_offset);
                    errors++;
                end
                if (o_voltage_offset !== t.vol_off) begin
                    $error("voltage_offset exp %h got %h", t.vol_off, o_voltage_offset);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL energy_meter_sample_accumulator");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 4; i++) m_coeff[i] = COEFF_RESET;
        m_gain = GAIN_RESET; m_beta = BETA_RESET; m_shift = POWER_SHIFT_RESET;
        m_cur_line = '0; m_vol_line = '0; m_pow_line = '0; m_prev_fv = '0;
        m_cur_raw = '0; m_vol_raw = '0; m_cur_sq = '0; m_vol_sq = '0;
        m_power = '0; m_count = '0; m_cur_off = '0; m_vol_off = '0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_req_type <= REQ_SAMPLE;
        i_current_sample <= '0;
        i_voltage_sample <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_extremes();
        test_config_extremes();
        test_backpressure();
        test_random_intervals();
        drain();
        if (errors == 0)
            $display("PASS energy_meter_sample_accumulator");
        else
            $display("FAIL energy_meter_sample_accumulator");
        $finish;
    end
endmodule
